>>> design/crs_pkg.sv
// shared types, constants and helpers of the chunk retransmit scheduler
package crs_pkg;

   // default sizing
   localparam int MAX_CHUNKS_DEF = 1024;
   localparam int CHANNELS_DEF   = 2;

   // bitmap word geometry
   localparam int WORD_W = 64;
   localparam int BIT_W  = $clog2(WORD_W);

   // fixed field widths
   localparam int CHUNK_W     = 10;
   localparam int CNT_REG_W   = 11;
   localparam int TRY_W       = 4;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHUNK_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TRIES   = 1'd1;

   // register reset values
   localparam logic [CNT_REG_W-1:0] CHUNK_COUNT_RST = 11'd1;
   localparam logic [TRY_W-1:0]     MAX_TRIES_RST   = 4'd3;

   typedef enum logic [1:0] {
      ACT_START   = 2'd0,
      ACT_ACK     = 2'd1,
      ACT_TIMEOUT = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_CLR_RD,
      ST_CLR_WR,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_RESP
   } state_type;

   typedef struct packed {
      action_type          action;
      logic                channel;
      logic [CHUNK_W-1:0]  acked_chunk;
   } req_type;

   typedef struct packed {
      logic                send;
      logic                resend;
      logic [CHUNK_W-1:0]  chunk;
      logic                final_chunk;
      logic                gave_up;
      logic                finished;
   } rsp_type;

   // address width of a store of the given depth, never below one bit
   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

>>> design/crs_bitmap.sv
// sent-chunk bitmap memory, one word per row, with per-row valid bits
module crs_bitmap #(
   parameter int WORDS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          rd_en,
   input  logic [crs_pkg::addr_width(WORDS)-1:0]         rd_addr,
   output logic [crs_pkg::WORD_W-1:0]                    rd_data,
   input  logic                                          wr_en,
   input  logic [crs_pkg::addr_width(WORDS)-1:0]         wr_addr,
   input  logic [crs_pkg::WORD_W-1:0]                    wr_data
);
   import crs_pkg::*;

   logic [WORD_W-1:0] mem [WORDS];
   logic              row_valid_ff [WORDS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORDS; i++) begin
            row_valid_ff[i] <= 1'b0;
         end
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   // a row never written reads as all clear
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> design/chunk_retransmit_scheduler.sv
// chunk retransmit scheduler top level: event sequencer around the sent bitmap
//
//  channel | ports                      | moves
//  --------+----------------------------+-------------------------------------
//  request | req_valid req_ready req_data | one event (action, channel, ack index)
//  result  | rsp_valid rsp_ready rsp_data | one result per event
//  config  | csr_we csr_index csr_wdata   | register write, no wait
//
// one event at a time: an idle state that takes the request, a decide state, a
// bitmap read-modify-write (clear read, clear write) when a chunk is returned,
// then a free-chunk scan for start/ack over at most ceil(chunk_count/64) bitmap
// words (a scan read, then a check per word), then the output register
// synchronous reset clears the per-row valid bits at once, so no clearing pass
// a result held in the output register stalls the next result, not the next
// request transfer
module chunk_retransmit_scheduler #(
   parameter int MAX_CHUNKS = crs_pkg::MAX_CHUNKS_DEF,
   parameter int CHANNELS   = crs_pkg::CHANNELS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  crs_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output crs_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [crs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [crs_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import crs_pkg::*;

   // bitmap geometry: one bit per chunk, 64 chunks per word
   localparam int WORDS = (MAX_CHUNKS + WORD_W - 1) / WORD_W;
   localparam int WA_W  = addr_width(WORDS);
   localparam int IDX_W = WA_W + BIT_W;
   localparam int CH_W  = addr_width(CHANNELS);
   localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
   // compare width holds the register, the capped count and any chunk index
   localparam int CMP_A = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;
   localparam int CMP_W = (CMP_A > IDX_W + 1) ? CMP_A : IDX_W + 1;

   // sequencer
   state_type            state_ff, state_in;
   req_type              item_ff, item_in;

   // per-channel state
   logic                 holding_ff [CHANNELS];
   logic                 holding_in [CHANNELS];
   logic [IDX_W-1:0]     held_ff    [CHANNELS];
   logic [IDX_W-1:0]     held_in    [CHANNELS];
   logic [TRY_W-1:0]     try_ff     [CHANNELS];
   logic [TRY_W-1:0]     try_in     [CHANNELS];
   logic                 final_acked_ff, final_acked_in;

   // registers
   logic [CNT_REG_W-1:0] chunk_count_ff, chunk_count_in;
   logic [TRY_W-1:0]     max_tries_ff, max_tries_in;

   // scan position and pending result
   logic [WA_W-1:0]      scan_word_ff, scan_word_in;
   logic                 res_send_ff, res_send_in;
   logic                 res_resend_ff, res_resend_in;
   logic                 res_gave_ff, res_gave_in;
   logic [IDX_W-1:0]     res_chunk_ff, res_chunk_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // bitmap port
   logic                 bm_rd_en, bm_wr_en;
   logic [WA_W-1:0]      bm_rd_addr, bm_wr_addr;
   logic [WORD_W-1:0]    bm_rd_data, bm_wr_data;

   // derived values
   logic [CMP_W-1:0]     cnt_raw, cnt_eff, cnt_m1;
   logic                 cnt_zero;
   logic [WA_W-1:0]      last_word;
   logic [BIT_W-1:0]     last_bit;
   logic [WORD_W-1:0]    low_mask, word_free;
   logic [BIT_W-1:0]     free_bit;
   logic                 ch_ok;
   logic [CH_W-1:0]      ch_idx;
   logic                 cur_hold;
   logic [IDX_W-1:0]     cur_held;
   logic [TRY_W-1:0]     cur_try;
   logic                 any_holding;
   logic [IDX_W-1:0]     found_idx;

   crs_bitmap #(
      .WORDS (WORDS)
   ) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (bm_rd_en),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_data (bm_wr_data)
   );

   // count capped at the bitmap size, last chunk index split into word and bit
   assign cnt_raw   = CMP_W'(chunk_count_ff);
   assign cnt_eff   = (cnt_raw > CMP_W'(MAX_CHUNKS)) ? CMP_W'(MAX_CHUNKS) : cnt_raw;
   assign cnt_zero  = (cnt_eff == '0);
   assign cnt_m1    = cnt_eff - CMP_W'(1);
   assign last_word = cnt_m1[IDX_W-1:BIT_W];
   assign last_bit  = cnt_m1[BIT_W-1:0];

   // only bits below the chunk count are candidates in the last word
   assign low_mask  = {WORD_W{1'b1}} >> (~last_bit);
   assign word_free = ~bm_rd_data & ((scan_word_ff == last_word) ? low_mask : '1);
   assign found_idx = {scan_word_ff, free_bit};

   // lowest free bit of the word under scan
   always_comb begin
      free_bit = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (word_free[i]) begin
            free_bit = BIT_W'(i);
         end
      end
   end

   // channel of the event in progress
   assign ch_ok    = (int'(item_ff.channel) < CHANNELS);
   assign ch_idx   = CH_W'(item_ff.channel);
   assign cur_hold = holding_ff[ch_idx];
   assign cur_held = held_ff[ch_idx];
   assign cur_try  = try_ff[ch_idx];

   always_comb begin
      any_holding = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         any_holding = any_holding | holding_ff[c];
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // next state and datapath control
   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      holding_in     = holding_ff;
      held_in        = held_ff;
      try_in         = try_ff;
      final_acked_in = final_acked_ff;
      chunk_count_in = chunk_count_ff;
      max_tries_in   = max_tries_ff;
      scan_word_in   = scan_word_ff;
      res_send_in    = res_send_ff;
      res_resend_in  = res_resend_ff;
      res_gave_in    = res_gave_ff;
      res_chunk_in   = res_chunk_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_data_in    = rsp_data_ff;
      bm_rd_en       = 1'b0;
      bm_rd_addr     = '0;
      bm_wr_en       = 1'b0;
      bm_wr_addr     = '0;
      bm_wr_data     = '0;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_CHUNK_COUNT: chunk_count_in = csr_wdata;
            CSR_MAX_TRIES:   max_tries_in   = csr_wdata[TRY_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            res_send_in   = 1'b0;
            res_resend_in = 1'b0;
            res_gave_in   = 1'b0;
            res_chunk_in  = '0;
            scan_word_in  = '0;
            state_in      = ST_RESP;
            if (ch_ok) begin
               case (item_ff.action)
                  ACT_START, ACT_ACK: begin
                     // release the held chunk; an ack keeps it marked sent
                     if (cur_hold) begin
                        holding_in[ch_idx] = 1'b0;
                     end
                     if (item_ff.action == ACT_ACK && !cnt_zero &&
                         CMP_W'(item_ff.acked_chunk) == cnt_m1) begin
                        final_acked_in = 1'b1;
                     end
                     if (cur_hold && item_ff.action == ACT_START) begin
                        state_in = ST_CLR_RD;
                     end else begin
                        state_in = ST_SCAN_RD;
                     end
                  end
                  ACT_TIMEOUT: begin
                     if (cur_hold) begin
                        if (cur_try < max_tries_ff) begin
                           try_in[ch_idx] = cur_try + TRY_W'(1);
                           res_send_in    = 1'b1;
                           res_resend_in  = 1'b1;
                           res_chunk_in   = cur_held;
                        end else begin
                           // try limit: hand the chunk back to the pool
                           holding_in[ch_idx] = 1'b0;
                           try_in[ch_idx]     = '0;
                           res_gave_in        = 1'b1;
                           state_in           = ST_CLR_RD;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_CLR_RD: begin
            bm_rd_en   = 1'b1;
            bm_rd_addr = cur_held[IDX_W-1:BIT_W];
            state_in   = ST_CLR_WR;
         end

         ST_CLR_WR: begin
            bm_wr_en   = 1'b1;
            bm_wr_addr = cur_held[IDX_W-1:BIT_W];
            bm_wr_data = bm_rd_data & ~(WORD_W'(1) << cur_held[BIT_W-1:0]);
            state_in   = (item_ff.action == ACT_TIMEOUT) ? ST_RESP : ST_SCAN_RD;
         end

         ST_SCAN_RD: begin
            if (cnt_zero) begin
               try_in[ch_idx] = '0;
               state_in       = ST_RESP;
            end else begin
               bm_rd_en   = 1'b1;
               bm_rd_addr = scan_word_ff;
               state_in   = ST_SCAN_CHK;
            end
         end

         ST_SCAN_CHK: begin
            if (word_free != '0) begin
               // take the chunk: mark it sent and give it to the channel
               bm_wr_en           = 1'b1;
               bm_wr_addr         = scan_word_ff;
               bm_wr_data         = bm_rd_data | (WORD_W'(1) << free_bit);
               holding_in[ch_idx] = 1'b1;
               held_in[ch_idx]    = found_idx;
               try_in[ch_idx]     = TRY_W'(1);
               res_send_in        = 1'b1;
               res_chunk_in       = found_idx;
               state_in           = ST_RESP;
            end else if (scan_word_ff == last_word) begin
               try_in[ch_idx] = '0;
               state_in       = ST_RESP;
            end else begin
               // next word read overlaps this check
               scan_word_in = scan_word_ff + WA_W'(1);
               bm_rd_en     = 1'b1;
               bm_rd_addr   = scan_word_ff + WA_W'(1);
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.send        = res_send_ff;
               rsp_data_in.resend      = res_resend_ff;
               rsp_data_in.chunk       = CHUNK_W'(res_chunk_ff);
               rsp_data_in.final_chunk = res_send_ff && !cnt_zero &&
                                         (CMP_W'(res_chunk_ff) == cnt_m1);
               rsp_data_in.gave_up     = res_gave_ff;
               rsp_data_in.finished    = final_acked_ff && !any_holding;
               state_in                = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         final_acked_ff <= 1'b0;
         chunk_count_ff <= CHUNK_COUNT_RST;
         max_tries_ff   <= MAX_TRIES_RST;
         rsp_valid_ff   <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            holding_ff[c] <= 1'b0;
            try_ff[c]     <= '0;
         end
      end else begin
         state_ff       <= state_in;
         final_acked_ff <= final_acked_in;
         chunk_count_ff <= chunk_count_in;
         max_tries_ff   <= max_tries_in;
         rsp_valid_ff   <= rsp_valid_in;
         holding_ff     <= holding_in;
         try_ff         <= try_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      held_ff       <= held_in;
      scan_word_ff  <= scan_word_in;
      res_send_ff   <= res_send_in;
      res_resend_ff <= res_resend_in;
      res_gave_ff   <= res_gave_in;
      res_chunk_ff  <= res_chunk_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

>>> bench/crs_checker.sv
`timescale 1ns / 1ps
// transfer monitor with result prediction and comparison for the chunk scheduler
module crs_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  crs_pkg::req_type                 req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  crs_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [crs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [crs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int unsigned                      mismatch_count,
   output int unsigned                      waiting_count
);
   import crs_pkg::*;

   // shadow copy of the scheduler state
   logic [MAX_CHUNKS_DEF-1:0] sent_bits;
   logic [MAX_CHUNKS_DEF-1:0] flight_bits;
   logic [CHUNK_W-1:0]        held_idx [CHANNELS_DEF];
   logic [CHANNELS_DEF-1:0]   holding_q;
   logic [TRY_W-1:0]          tries_used [CHANNELS_DEF];
   logic                      final_seen;
   logic [CNT_REG_W-1:0]      cfg_chunks;
   logic [TRY_W-1:0]          cfg_tries;

   rsp_type     due_results [$];
   int unsigned mismatches = 0;

   assign mismatch_count = mismatches;

   // applies one event to the shadow state and returns the result it causes
   function automatic rsp_type schedule_event(input req_type ev);
      rsp_type            r;
      int                 n;
      int                 pick;
      logic [CHUNK_W-1:0] h;
      r = '0;
      n = (cfg_chunks > MAX_CHUNKS_DEF) ? MAX_CHUNKS_DEF : int'(cfg_chunks);
      h = held_idx[ev.channel];
      if (ev.action == ACT_START || ev.action == ACT_ACK) begin
         // release the held chunk, a start also puts it back in the pool
         if (holding_q[ev.channel]) begin
            flight_bits[h] = 1'b0;
            if (ev.action == ACT_START)
               sent_bits[h] = 1'b0;
            holding_q[ev.channel] = 1'b0;
         end
         if (ev.action == ACT_ACK && n > 0 && int'(ev.acked_chunk) == n - 1)
            final_seen = 1'b1;
         pick = -1;
         for (int i = 0; i < n; i++)
            if (pick < 0 && !sent_bits[i] && !flight_bits[i])
               pick = i;
         if (pick >= 0) begin
            sent_bits[pick]        = 1'b1;
            flight_bits[pick]      = 1'b1;
            held_idx[ev.channel]   = CHUNK_W'(pick);
            holding_q[ev.channel]  = 1'b1;
            tries_used[ev.channel] = TRY_W'(1);
            r.send                 = 1'b1;
            r.chunk                = CHUNK_W'(pick);
         end else begin
            tries_used[ev.channel] = '0;
         end
      end else if (ev.action == ACT_TIMEOUT && holding_q[ev.channel]) begin
         if (tries_used[ev.channel] < cfg_tries) begin
            tries_used[ev.channel] = tries_used[ev.channel] + 1'b1;
            r.send   = 1'b1;
            r.resend = 1'b1;
            r.chunk  = h;
         end else begin
            sent_bits[h]           = 1'b0;
            flight_bits[h]         = 1'b0;
            holding_q[ev.channel]  = 1'b0;
            tries_used[ev.channel] = '0;
            r.gave_up              = 1'b1;
         end
      end
      r.final_chunk = r.send && n > 0 && int'(r.chunk) == n - 1;
      r.finished    = final_seen && (holding_q == '0);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      logic    bad;
      if (reset) begin
         sent_bits   = '0;
         flight_bits = '0;
         holding_q   = '0;
         final_seen  = 1'b0;
         cfg_chunks  = CHUNK_COUNT_RST;
         cfg_tries   = MAX_TRIES_RST;
         for (int c = 0; c < CHANNELS_DEF; c++) begin
            held_idx[c]   = '0;
            tries_used[c] = '0;
         end
         due_results.delete();
      end else begin
         // check before queueing so a same-edge request never matches itself
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with nothing expected: chunk=%0d send=%0d",
                           $realtime, rsp_data.chunk, rsp_data.send);
            end else begin
               want = due_results.pop_front();
               bad  = (rsp_data.send !== want.send) || (rsp_data.resend !== want.resend)
                   || (rsp_data.chunk !== want.chunk)
                   || (rsp_data.final_chunk !== want.final_chunk)
                   || (rsp_data.gave_up !== want.gave_up)
                   || (rsp_data.finished !== want.finished);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: mismatch send/resend/chunk/final/gave_up/finished",
                              $realtime);
                     $display("   exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                              want.send, want.resend, want.chunk,
                              want.final_chunk, want.gave_up, want.finished,
                              rsp_data.send, rsp_data.resend, rsp_data.chunk,
                              rsp_data.final_chunk, rsp_data.gave_up, rsp_data.finished);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            due_results.push_back(schedule_event(req_data));
         if (csr_we) begin
            if (csr_index == CSR_CHUNK_COUNT)
               cfg_chunks = csr_wdata[CNT_REG_W-1:0];
            else if (csr_index == CSR_MAX_TRIES)
               cfg_tries = csr_wdata[TRY_W-1:0];
         end
      end
      waiting_count = due_results.size();
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// top of the chunk scheduler bench: clock, reset, stimulus, flow control and verdict
module tb_top;
   import crs_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 6;
   localparam int PHASES       = 8;
   localparam int PHASE_EVENTS = 48;
   // the tail covers the longest event with margin
   localparam int END_SETTLE   = 40;
   // cycles without any transfer or register write before the run is declared hung
   localparam int STALL_LIMIT  = 2000;

   // action code outside the defined set, must leave the state alone
   localparam logic [1:0] ACT_UNKNOWN = 2'd3;

   // receiver back-pressure styles
   typedef enum logic [1:0] {
      RX_STEADY,
      RX_COIN,
      RX_SPARSE,
      RX_MOSTLY
   } rx_mode_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_CHUNK_COUNT;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int unsigned mismatch_count;
   int unsigned waiting_count;
   int unsigned events_sent  = 0;
   int unsigned results_seen = 0;
   int unsigned quiet_cycles = 0;

   rx_mode_type rx_mode  = RX_STEADY;
   int unsigned rx_left  = 0;
   logic [1:0]  rx_phase = '0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   chunk_retransmit_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   crs_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .waiting_count  (waiting_count)
   );

   // result transfers seen here; nonblocking so waiters read the pre-edge count
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         results_seen <= results_seen + 1;
   end

   // receiver: switches between back-pressure styles at random,
   // including stretches where it never stalls
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(16, 80);
      end else begin
         rx_left <= rx_left - 1;
      end
      rx_phase <= rx_phase + 1'b1;
      case (rx_mode)
         RX_STEADY: rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= (rx_phase == 2'd0);
         default:   rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // hang detection: any transfer or register write restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < STALL_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic req_type ev_of(input logic [1:0] act, input logic ch,
                                     input logic [CHUNK_W-1:0] acked);
      req_type ev;
      ev.action      = action_type'(act);
      ev.channel     = ch;
      ev.acked_chunk = acked;
      return ev;
   endfunction

   // raises valid with the payload and holds both until the transfer happens;
   // returns in the time step of the accepting edge with valid still high
   task automatic push_event(input req_type ev);
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      events_sent++;
   endtask

   // drops valid and waits until every transfer has its result back
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_seen != events_sent)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      req_type              ev;
      int unsigned          n_eff;
      int unsigned          burst_left;
      int unsigned          gap;
      int unsigned          pick;
      logic [CNT_REG_W-1:0] cnt;
      logic [TRY_W-1:0]     lim;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset settings: one chunk, three tries
      push_event(ev_of(ACT_TIMEOUT, 1'b0, '0));          // timeout on an idle channel
      push_event(ev_of(ACT_UNKNOWN, 1'b1, '1));          // unknown action
      push_event(ev_of(ACT_ACK, 1'b1, '0));              // ack while idle, final index
      push_event(ev_of(ACT_START, 1'b0, '0));            // no free chunk left
      push_event(ev_of(ACT_TIMEOUT, 1'b1, '0));          // retries up to the limit
      push_event(ev_of(ACT_TIMEOUT, 1'b1, '0));
      push_event(ev_of(ACT_TIMEOUT, 1'b1, '0));          // limit hit, chunk given back
      push_event(ev_of(ACT_START, 1'b1, '0));
      push_event(ev_of(ACT_START, 1'b1, '0));            // start while holding
      push_event(ev_of(ACT_ACK, 1'b0, '0));
      push_event(ev_of(ACT_ACK, 1'b1, '1));              // ack of a foreign index
      settle_block();

      // empty transfer and zero tries
      write_reg(CSR_CHUNK_COUNT, '0);
      write_reg(CSR_MAX_TRIES, '0);
      push_event(ev_of(ACT_START, 1'b0, '0));
      push_event(ev_of(ACT_ACK, 1'b1, '0));
      push_event(ev_of(ACT_TIMEOUT, 1'b0, '1));
      settle_block();

      // count beyond the bitmap size, first timeout gives up at once
      write_reg(CSR_CHUNK_COUNT, '1);
      push_event(ev_of(ACT_START, 1'b0, '0));
      push_event(ev_of(ACT_TIMEOUT, 1'b0, '0));
      push_event(ev_of(ACT_START, 1'b1, '0));
      push_event(ev_of(ACT_ACK, 1'b0, '1));
      push_event(ev_of(ACT_UNKNOWN, 1'b0, '0));
      settle_block();

      // full-size transfer, highest try limit
      write_reg(CSR_CHUNK_COUNT, CSR_DATA_W'(MAX_CHUNKS_DEF));
      write_reg(CSR_MAX_TRIES, CSR_DATA_W'(15));
      push_event(ev_of(ACT_START, 1'b0, '0));
      repeat (4) push_event(ev_of(ACT_TIMEOUT, 1'b0, '0));
      push_event(ev_of(ACT_ACK, 1'b1, '1));
      settle_block();

      // random phases: small transfers run dry and finish, large ones cross
      // bitmap word boundaries; the sent map carries over between phases
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       begin cnt = 11'd3;    lim = 4'd1;  end
            1:       begin cnt = 11'd8;    lim = 4'd15; end
            2:       begin cnt = 11'd65;   lim = 4'd2;  end
            3:       begin cnt = 11'd130;  lim = 4'd0;  end
            4:       begin cnt = 11'd1023; lim = 4'd4;  end
            5:       begin cnt = 11'd2047; lim = 4'd5;  end
            6:       begin cnt = 11'd1;    lim = 4'd3;  end
            default: begin cnt = 11'd1024; lim = 4'd7;  end
         endcase
         write_reg(CSR_CHUNK_COUNT, cnt);
         write_reg(CSR_MAX_TRIES, CSR_DATA_W'(lim));
         n_eff      = (cnt > MAX_CHUNKS_DEF) ? MAX_CHUNKS_DEF : cnt;
         burst_left = $urandom_range(1, 12);
         for (int i = 0; i < PHASE_EVENTS; i++) begin
            pick           = $urandom_range(0, 99);
            ev.channel     = 1'($urandom_range(0, 1));
            ev.acked_chunk = CHUNK_W'($urandom_range(0, 1023));
            if (pick < 40) begin
               // acks mostly carry an index inside the transfer, often the last one
               ev.action = ACT_ACK;
               if (n_eff > 0 && $urandom_range(0, 2) != 0)
                  ev.acked_chunk = ($urandom_range(0, 1) != 0) ? CHUNK_W'(n_eff - 1)
                                 : CHUNK_W'($urandom_range(0, n_eff - 1));
            end else if (pick < 62) begin
               ev.action = ACT_START;
            end else if (pick < 94) begin
               ev.action = ACT_TIMEOUT;
            end else begin
               ev.action = action_type'(ACT_UNKNOWN);
            end
            push_event(ev);
            burst_left--;
            // end of a burst: sometimes idle for a random gap, sometimes not at all
            if (burst_left == 0 && i != PHASE_EVENTS - 1) begin
               gap = $urandom_range(0, 6);
               if (gap != 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
            end
         end
         settle_block();
      end

      repeat (END_SETTLE) @(posedge clock);
      if (mismatch_count == 0 && waiting_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
design/crs_pkg.sv
design/crs_bitmap.sv
design/chunk_retransmit_scheduler.sv
bench/crs_checker.sv
bench/tb_top.sv
